### hdl/assert_macros.svh
// Assertion macros shared by the atomic memory operation unit.
// No dependencies; included by atomic_memory_op_unit, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AMO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AMO_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hdl/amo_pkg.sv
// Package of the atomic memory operation unit: sizes, operation codes, types.
// No dependencies; used by amo_alu, atomic_memory_op_unit and the testbench.
package amo_pkg;

    localparam int NUM_WORDS = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    localparam int KIND_BITS = 4;
    localparam int INDEX_BITS = 8;
    localparam int FIELD_BITS = 32;

    localparam logic [KIND_BITS-1:0] KIND_GET  = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_SET  = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_CLR  = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_ADD  = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_SUB  = 4'd4;
    localparam logic [KIND_BITS-1:0] KIND_INC  = 4'd5;
    localparam logic [KIND_BITS-1:0] KIND_DEC  = 4'd6;
    localparam logic [KIND_BITS-1:0] KIND_OR   = 4'd7;
    localparam logic [KIND_BITS-1:0] KIND_XOR  = 4'd8;
    localparam logic [KIND_BITS-1:0] KIND_AND  = 4'd9;
    localparam logic [KIND_BITS-1:0] KIND_NAND = 4'd10;
    localparam logic [KIND_BITS-1:0] KIND_CAS  = 4'd11;

    typedef logic [WORD_BITS-1:0] word_t;

    // Operation applied to one word.
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        word_t                opv;
        word_t                cmp;
    } amo_op_t;

    // What the operation unit hands back.
    typedef struct packed {
        word_t next_word;
        logic  swap_done;
    } amo_res_t;

endpackage

### hdl/amo_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module amo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/amo_alu.sv
// Modify step of the read-modify-write: computes the new word from the old one.
// Depends on amo_pkg.
module amo_alu
    import amo_pkg::*;
(
    input  word_t    prior,
    input  amo_op_t  op,
    output amo_res_t res
);

    always_comb begin
        res.next_word = prior;
        res.swap_done = 1'b0;
        case (op.kind)
            KIND_SET:  res.next_word = op.opv;
            KIND_CLR:  res.next_word = '0;
            KIND_ADD:  res.next_word = prior + op.opv;
            KIND_SUB:  res.next_word = prior - op.opv;
            KIND_INC:  res.next_word = prior + word_t'(1);
            KIND_DEC:  res.next_word = prior - word_t'(1);
            KIND_OR:   res.next_word = prior | op.opv;
            KIND_XOR:  res.next_word = prior ^ op.opv;
            KIND_AND:  res.next_word = prior & op.opv;
            KIND_NAND: res.next_word = ~(prior & op.opv);
            KIND_CAS: begin
                if (prior == op.cmp) begin
                    res.next_word = op.opv;
                    res.swap_done = 1'b1;
                end
            end
            default:   res.next_word = prior;
        endcase
    end

endmodule

### hdl/atomic_memory_op_unit.sv
// Atomic memory operation unit: word store in a RAM, modify logic, result register.
// Depends on amo_pkg, amo_ram, amo_alu and assert_macros.svh.
//
// Usage:
//   A request transfer on the s_ channel (s_valid/s_ready) names a word, a kind
//   and operand values. For every request exactly one result transfer leaves on
//   the m_ channel (m_valid/m_ready): the word's value before the request acted
//   on it and, for compare-and-swap, a flag that the swap took place.
//   A request passes the RAM read, then the modify, write-back and result
//   register before m_valid rises. Throughput is one request per cycle while
//   the receiver does not stall. A request that reads a word written back in
//   the same cycle takes the new value from a forwarding register, so
//   back-to-back requests to one word stay atomic.
//   When the receiver stalls, the result register holds its transfer, the
//   request in the modify stage waits, and s_ready drops once that stage is
//   full; nothing is lost or repeated.
//   Reset clears the control state and one valid bit per word at once; a word
//   whose valid bit is clear reads as zero, so there is no clearing pass and
//   the block takes requests in the first cycle after reset.
//   An index beyond the store returns zero and leaves the store untouched.
module atomic_memory_op_unit
    import amo_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_BITS-1:0]  s_kind,
    input  logic [INDEX_BITS-1:0] s_word_index,
    input  logic [FIELD_BITS-1:0] s_operand,
    input  logic [FIELD_BITS-1:0] s_compare_value,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FIELD_BITS-1:0] m_prior_word,
    output logic                  m_swap_done
);

`include "assert_macros.svh"

    // Request transfer and address of the read it starts.
    logic                 s_accept;
    logic [ADDR_BITS-1:0] s_addr;
    logic                 s_in_range;

    // Modify stage: the request whose RAM read has just completed.
    logic                 s1_valid_reg;
    logic [ADDR_BITS-1:0] s1_addr_reg;
    logic                 s1_in_range_reg;
    amo_op_t              s1_op_reg;
    logic                 s1_hit_reg;    // word was written in the cycle of the read
    word_t                s1_fwd_reg;    // the value written then
    logic                 s1_vld_reg;    // word had been written since reset
    logic                 s1_adv;

    // One valid bit per word; a clear bit means the word still holds zero.
    logic [NUM_WORDS-1:0] vld_reg;
    logic [NUM_WORDS-1:0] vld_next;

    // Write-back port.
    logic                 ram_we;
    word_t                ram_rdata;
    word_t                prior;
    amo_res_t             alu_res;

    // Result register.
    logic                 m_valid_reg;
    word_t                m_prior_reg;
    logic                 m_swap_reg;

    assign s_in_range = ({1'b0, s_word_index} < (INDEX_BITS + 1)'(NUM_WORDS));
    assign s_addr     = ADDR_BITS'(s_word_index);

    // The modify stage moves on when the result register is empty or being taken.
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    assign ram_we = s1_adv && s1_in_range_reg;

    amo_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (alu_res.next_word),
        .re    (s_accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    // The word as it stands: forwarded write, stored value, or zero if untouched.
    always_comb begin
        if (!s1_in_range_reg) begin
            prior = '0;
        end else if (s1_hit_reg) begin
            prior = s1_fwd_reg;
        end else if (s1_vld_reg) begin
            prior = ram_rdata;
        end else begin
            prior = '0;
        end
    end

    amo_alu u_alu (
        .prior (prior),
        .op    (s1_op_reg),
        .res   (alu_res)
    );

    always_comb begin
        vld_next = vld_reg;
        if (ram_we) begin
            vld_next[s1_addr_reg] = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            vld_reg      <= '0;
        end else begin
            vld_reg <= vld_next;
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the modify stage and of the result register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg     <= s_addr;
            s1_in_range_reg <= s_in_range;
            s1_op_reg.kind  <= s_kind;
            s1_op_reg.opv   <= WORD_BITS'(s_operand);
            s1_op_reg.cmp   <= WORD_BITS'(s_compare_value);
            s1_hit_reg      <= ram_we && (s1_addr_reg == s_addr);
            s1_fwd_reg      <= alu_res.next_word;
            s1_vld_reg      <= vld_reg[s_addr];
        end
        if (s1_adv) begin
            m_prior_reg <= prior;
            m_swap_reg  <= alu_res.swap_done && s1_in_range_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prior_word = FIELD_BITS'(m_prior_reg);
    assign m_swap_done  = m_swap_reg;

    // The store is written only by a request leaving the modify stage.
    `AMO_ASSERT_IMP(a_write_on_advance, aclk, aresetn, ram_we, s1_adv && s1_valid_reg)
    // A full modify stage that cannot move on holds off new requests.
    `AMO_ASSERT_IMP(a_ready_backpressure, aclk, aresetn, s1_valid_reg && !s1_adv, !s_ready)
    // A read of the word being written back must pick up the forwarded value.
    `AMO_ASSERT_NXT(a_forward_taken, aclk, aresetn,
        s_accept && ram_we && (s1_addr_reg == s_addr), s1_hit_reg)
    // A swap is reported only when the word matched the compare value.
    `AMO_ASSERT_IMP(a_swap_matches, aclk, aresetn,
        s1_adv && alu_res.swap_done, (prior == s1_op_reg.cmp) && (s1_op_reg.kind == KIND_CAS))

endmodule

### test/tb_top.sv
// Self-checking testbench for atomic_memory_op_unit: directed and random request traffic,
// random stalls on both channels, and an in-order prediction of every result.
// Depends on amo_pkg and the RTL of the unit; nothing else.
module tb_top;
    import amo_pkg::*;

    // Kinds above compare-and-swap carry no operation and must behave like a get.
    localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 4'd12;
    localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 4'd15;

    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int LONG_HOLD      = 120;   // receiver hold-off that backs up the pipeline
    localparam int SETTLE_CYCLES  = 10;    // margin after the last transfer before the final check
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either channel

    // One request as the stimulus plans it, with the idle time in front of it.
    typedef struct {
        logic [KIND_BITS-1:0]  kind;
        logic [INDEX_BITS-1:0] word_index;
        logic [FIELD_BITS-1:0] operand;
        logic [FIELD_BITS-1:0] compare_value;
        int unsigned           gap;
        bit                    drain_first;  // wait until every result has come back
    } request_t;

    typedef struct {
        logic [FIELD_BITS-1:0] prior_word;
        logic                  swap_done;
    } amo_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [KIND_BITS-1:0]  s_kind = '0;
    logic [INDEX_BITS-1:0] s_word_index = '0;
    logic [FIELD_BITS-1:0] s_operand = '0;
    logic [FIELD_BITS-1:0] s_compare_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [FIELD_BITS-1:0] m_prior_word;
    logic                  m_swap_done;

    request_t    pending_requests[$];
    amo_reply_t  awaited_results[$];
    word_t       word_mirror[NUM_WORDS];  // store as the checker sees it, updated on acceptance
    word_t       plan_mirror[NUM_WORDS];  // store as the generator sees it, for CAS hits

    // Shared counters outstanding and results_seen use nonblocking assignments, so a
    // process reading them at a clock edge always sees the value from before that edge.
    int          outstanding = 0;
    int          results_seen = 0;
    int          fail_count = 0;
    int          quiet_cycles = 0;

    int unsigned gap_left = 0;
    bit          gap_armed = 1'b0;
    int unsigned stall_left = 0;
    bit          long_hold_done = 1'b0;

    atomic_memory_op_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_word_index    (s_word_index),
        .s_operand       (s_operand),
        .s_compare_value (s_compare_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prior_word    (m_prior_word),
        .m_swap_done     (m_swap_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Value a word takes after one operation. Arithmetic wraps at the word width, kinds
    // without an operation leave the word alone, and only a matching CAS writes.
    function automatic word_t modify_word(input logic [KIND_BITS-1:0] kind, input word_t prior,
                                          input word_t opv, input word_t cmp,
                                          output logic swapped);
        word_t updated;
        updated = prior;
        swapped = 1'b0;
        case (kind)
            KIND_SET:  updated = opv;
            KIND_CLR:  updated = '0;
            KIND_ADD:  updated = prior + opv;
            KIND_SUB:  updated = prior - opv;
            KIND_INC:  updated = prior + word_t'(1);
            KIND_DEC:  updated = prior - word_t'(1);
            KIND_OR:   updated = prior | opv;
            KIND_XOR:  updated = prior ^ opv;
            KIND_AND:  updated = prior & opv;
            KIND_NAND: updated = ~(prior & opv);
            KIND_CAS: begin
                if (prior == cmp) begin
                    updated = opv;
                    swapped = 1'b1;
                end
            end
            default: updated = prior;
        endcase
        return updated;
    endfunction

    // Queues a request and keeps the generator's copy of the store in step with it.
    task automatic add_request(input logic [KIND_BITS-1:0] kind,
                               input logic [INDEX_BITS-1:0] word_index,
                               input logic [FIELD_BITS-1:0] operand,
                               input logic [FIELD_BITS-1:0] compare_value,
                               input int unsigned gap, input bit drain_first);
        request_t req;
        logic     swapped;
        req.kind = kind;
        req.word_index = word_index;
        req.operand = operand;
        req.compare_value = compare_value;
        req.gap = gap;
        req.drain_first = drain_first;
        pending_requests.push_back(req);
        if (int'(word_index) < NUM_WORDS)
            plan_mirror[word_index] = modify_word(kind, plan_mirror[word_index],
                                                  WORD_BITS'(operand), WORD_BITS'(compare_value),
                                                  swapped);
    endtask

    // Idle time in front of a request: mostly none, often a few cycles, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Driver. A new request goes out at the edge where the previous one is taken, or
    // after its gap has run out. A request marked drain_first is held back until the
    // sender is idle and every result it caused has come back.
    always @(posedge aclk) begin : driver
        request_t head;
        bit       start_next;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_armed = 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            start_next = 1'b0;
            if (pending_requests.size() != 0) begin
                head = pending_requests[0];
                if (!gap_armed) begin
                    gap_left = head.gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0)
                    gap_left--;
                else if (!head.drain_first || (!s_valid && outstanding == 0))
                    start_next = 1'b1;
            end
            if (start_next) begin
                head = pending_requests.pop_front();
                gap_armed = 1'b0;
                s_kind <= head.kind;
                s_word_index <= head.word_index;
                s_operand <= head.operand;
                s_compare_value <= head.compare_value;
            end
            s_valid <= start_next;
        end
    end

    // Receiver. Short random stalls most of the time, a stretch with no stalls, and one
    // long hold-off so the unit fills up and has to drop s_ready.
    always @(posedge aclk) begin : receiver
        int unsigned roll;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 500) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (results_seen >= 1200 && results_seen < 1400) begin
            m_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                m_ready <= 1'b1;
            end else if (roll < 95) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                stall_left = $urandom_range(10, 25);
                m_ready <= 1'b0;
            end
        end
    end

    // Monitor. A result transfer is checked against the oldest awaited result before a
    // request transfer in the same cycle adds its own, so the order never matters.
    always @(posedge aclk) begin : monitor
        amo_reply_t want;
        logic       swapped;
        word_t      prior;
        int         taken;
        int         given;
        taken = 0;
        given = 0;
        if (!aresetn) begin
            for (int w = 0; w < NUM_WORDS; w++)
                word_mirror[w] = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with none awaited: prior_word %h swap_done %b",
                           m_prior_word, m_swap_done);
                    fail_count++;
                end else begin
                    given = 1;
                    want = awaited_results.pop_front();
                    if (m_prior_word !== want.prior_word) begin
                        $error("prior_word: expected %h, got %h", want.prior_word,
                               m_prior_word);
                        fail_count++;
                    end
                    if (m_swap_done !== want.swap_done) begin
                        $error("swap_done: expected %b, got %b", want.swap_done, m_swap_done);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken = 1;
                if (int'(s_word_index) >= NUM_WORDS) begin
                    // An index beyond the store reads as zero and changes nothing.
                    want.prior_word = '0;
                    want.swap_done = 1'b0;
                end else begin
                    prior = word_mirror[s_word_index];
                    word_mirror[s_word_index] = modify_word(s_kind, prior,
                                                            WORD_BITS'(s_operand),
                                                            WORD_BITS'(s_compare_value),
                                                            swapped);
                    want.prior_word = FIELD_BITS'(prior);
                    want.swap_done = swapped;
                end
                awaited_results.push_back(want);
            end
            outstanding <= outstanding + taken - given;
            results_seen <= results_seen + given;
        end
    end

    // Watchdog: a long run of cycles with no transfer at all means the unit is stuck.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [KIND_BITS-1:0]  kind;
        logic [INDEX_BITS-1:0] word_index;
        logic [FIELD_BITS-1:0] operand;
        logic [FIELD_BITS-1:0] compare_value;
        int unsigned           gap;
        for (int w = 0; w < NUM_WORDS; w++)
            plan_mirror[w] = '0;

        // Directed part, back to back so that forwarding between requests to one word is
        // exercised: extremes of index and operand, wrap in both directions, every
        // logic operation, CAS hit and miss, and the spare kinds.
        add_request(KIND_GET,  8'd0,   32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_SET,  8'd255, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_INC,  8'd255, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_DEC,  8'd0,   32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_GET,  8'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(KIND_ADD,  8'd0,   32'h0000_0001, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_SUB,  8'd0,   32'h0000_0001, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_SET,  8'd1,   32'hA5A5_A5A5, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_OR,   8'd1,   32'h0F0F_0F0F, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_XOR,  8'd1,   32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_AND,  8'd1,   32'h00FF_00FF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_NAND, 8'd1,   32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_CAS,  8'd1,   32'hDEAD_BEEF, 32'h1234_5678, 0, 1'b0);
        add_request(KIND_CAS,  8'd1,   32'h0000_0000, plan_mirror[1], 0, 1'b0);
        add_request(KIND_CLR,  8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(KIND_SPARE_LO, 8'd1, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_SPARE_HI, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(KIND_ADD,  8'd128, 32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_SUB,  8'd128, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_CAS,  8'd2,   32'hFFFF_FFFF, 32'h0000_0000, 0, 1'b0);
        add_request(KIND_CAS,  8'd2,   32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(KIND_GET,  8'd2,   32'h0000_0000, 32'h0000_0000, 0, 1'b0);

        // Random part. Half the traffic goes to a few hot words so that values build up
        // and CAS compares often hit; a window with no gaps meets the receiver's long
        // hold-off, and three times the sender drains the unit completely before going on.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(0, 99) < 50) begin
                case ($urandom_range(0, 3))
                    0:       word_index = 8'd0;
                    1:       word_index = 8'd1;
                    2:       word_index = 8'd254;
                    default: word_index = 8'd255;
                endcase
            end else begin
                word_index = INDEX_BITS'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 99) < 20)
                kind = KIND_CAS;
            else
                kind = KIND_BITS'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0:       operand = $urandom_range(0, 15);
                1:       operand = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: operand = $urandom;
            endcase
            if (kind == KIND_CAS && $urandom_range(0, 1) == 1)
                compare_value = plan_mirror[word_index];
            else
                compare_value = $urandom;
            gap = (i >= 300 && i < 700) ? 0 : pick_gap();
            add_request(kind, word_index, operand, compare_value, gap,
                        i == 0 || i == 1000 || i == 1500);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample on the falling edge, where every process of the rising edge has settled.
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (awaited_results.size() != 0)
            $error("%0d results never arrived", awaited_results.size());
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/amo_pkg.sv
hdl/amo_ram.sv
hdl/amo_alu.sv
hdl/atomic_memory_op_unit.sv
test/tb_top.sv
